[rtl/core/dtg_pkg.sv]
// Shared types and constants for the grouped decimal text block.
// Used by dtg_ctrl, dtg_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtg_pkg;

    // Width of the signed integer that is formatted (8 to 64)
    localparam int NUMBER_WIDTH = 64;
    // Counter for the binary-to-BCD shift steps
    localparam int BIT_CNT_W    = $clog2(NUMBER_WIDTH);
    // Decimal digits held in the BCD register (enough for 2^64)
    localparam int MAX_DIGITS   = 20;
    localparam int BCD_W        = 4 * MAX_DIGITS;
    localparam int REM_W        = $clog2(MAX_DIGITS + 1);
    // MAX_DIGITS modulo the group size
    localparam logic [1:0] MAX_DIGITS_MOD3 = 2'(MAX_DIGITS % 3);

    // ASCII characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_COMMA
    } t_state;

    // Datapath commands
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CONV,
        OP_SKIP,
        OP_SIGN,
        OP_DIGIT,
        OP_COMMA
    } t_dp_op;

    // Datapath status back to the controller
    typedef struct packed {
        logic conv_last;  // last binary-to-BCD step
        logic top_zero;   // leading BCD digit is zero
        logic rem_one;    // one digit left
        logic mod3_one;   // digits left, modulo 3, is one
        logic neg;        // number is negative
        logic out_free;   // output register can take a character
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/dtg_datapath.sv]
// Datapath: operand capture, shift-add-3 binary-to-BCD conversion,
// leading-zero skip, digit counting and the output character register.
// Depends on dtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtg_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [63:0]         i_number_in,
    input  wire dtg_pkg::t_dp_op     i_op,
    output dtg_pkg::t_dp_status      o_status,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output logic [7:0]               o_text_char,
    output logic                     o_final_char
);
    import dtg_pkg::*;

    logic [NUMBER_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]        r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [1:0]              r_mod3, n_mod3;
    logic                    r_neg, n_neg;
    logic                    r_out_valid, n_out_valid;
    logic [7:0]              r_char, n_char;
    logic                    r_final, n_final;

    logic [NUMBER_WIDTH-1:0] raw;
    logic [BCD_W-1:0]        bcd_adj;
    logic [3:0]              top_digit;
    logic [1:0]              mod3_dec;
    logic                    out_free;

    // Operand slice, leading BCD digit, group phase step and output-free check
    assign raw       = i_number_in[NUMBER_WIDTH-1:0];
    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign mod3_dec  = (r_mod3 == 2'd0) ? 2'd2 : (r_mod3 - 2'd1);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Add 3 to every BCD digit of five or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            d = r_bcd[4*k +: 4];
            bcd_adj[4*k +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // Next-state for the datapath registers
    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_rem       = r_rem;
        n_mod3      = r_mod3;
        n_neg       = r_neg;
        n_char      = r_char;
        n_final     = r_final;
        n_out_valid = r_out_valid && i_out_stall;
        case (i_op)
            OP_LOAD: begin
                n_neg     = raw[NUMBER_WIDTH-1];
                n_bin     = raw[NUMBER_WIDTH-1] ? (~raw + NUMBER_WIDTH'(1)) : raw;
                n_bcd     = '0;
                n_bit_cnt = BIT_CNT_W'(NUMBER_WIDTH - 1);
                n_rem     = REM_W'(MAX_DIGITS);
                n_mod3    = MAX_DIGITS_MOD3;
            end
            OP_CONV: begin
                n_bcd     = {bcd_adj[BCD_W-2:0], r_bin[NUMBER_WIDTH-1]};
                n_bin     = {r_bin[NUMBER_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
            end
            OP_SKIP: begin
                n_bcd  = {r_bcd[BCD_W-5:0], 4'h0};
                n_rem  = r_rem - REM_W'(1);
                n_mod3 = mod3_dec;
            end
            OP_SIGN: begin
                n_out_valid = 1'b1;
                n_char      = CHAR_MINUS;
                n_final     = 1'b0;
            end
            OP_DIGIT: begin
                n_out_valid = 1'b1;
                n_char      = CHAR_ZERO + {4'h0, top_digit};
                n_final     = (r_rem == REM_W'(1));
                n_bcd       = {r_bcd[BCD_W-5:0], 4'h0};
                n_rem       = r_rem - REM_W'(1);
                n_mod3      = mod3_dec;
            end
            OP_COMMA: begin
                n_out_valid = 1'b1;
                n_char      = CHAR_COMMA;
                n_final     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rem       <= REM_W'(MAX_DIGITS);
            r_mod3      <= MAX_DIGITS_MOD3;
        end else begin
            r_out_valid <= n_out_valid;
            r_rem       <= n_rem;
            r_mod3      <= n_mod3;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_neg     <= n_neg;
        r_char    <= n_char;
        r_final   <= n_final;
    end

    // Status to the controller
    assign o_status.conv_last = (r_bit_cnt == '0);
    assign o_status.top_zero  = (top_digit == 4'h0);
    assign o_status.rem_one   = (r_rem == REM_W'(1));
    assign o_status.mod3_one  = (r_mod3 == 2'd1);
    assign o_status.neg       = r_neg;
    assign o_status.out_free  = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_text_char  = r_char;
    assign o_final_char = r_final;

`ifndef SYNTHESIS
    // Digit count stays within the BCD register
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= REM_W'(MAX_DIGITS))
        else $error("digit counter out of range");

    // Group phase never reaches three
    a_mod3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod3 != 2'd3)
        else $error("group phase out of range");

    // The last character is always a digit
    a_final_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_final) |-> (r_char >= CHAR_ZERO && r_char <= 8'h39))
        else $error("final flag on a non-digit");

    // A new character is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (i_op != OP_SIGN && i_op != OP_DIGIT
                                          && i_op != OP_COMMA))
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/core/dtg_ctrl.sv]
// Controller state machine: sequences load, conversion, leading-zero
// skip and character emission. Depends on dtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtg_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dtg_pkg::t_dp_status i_status,
    output dtg_pkg::t_dp_op          o_op
);
    import dtg_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                o_op = OP_CONV;
                if (i_status.conv_last) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (i_status.top_zero && !i_status.rem_one) begin
                    o_op = OP_SKIP;
                end else if (i_status.neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_op    = OP_SIGN;
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_status.out_free) begin
                    o_op = OP_DIGIT;
                    if (i_status.rem_one) begin
                        n_state = ST_IDLE;
                    end else if (i_status.mod3_one) begin
                        n_state = ST_COMMA;
                    end else begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_COMMA: begin
                if (i_status.out_free) begin
                    o_op    = OP_COMMA;
                    n_state = ST_DIGIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    // Skip phase only follows the conversion
    a_skip_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP && $past(r_state) != ST_SKIP) |->
            ($past(r_state) == ST_CONV))
        else $error("skip entered without conversion");

    // A comma is always followed by a digit
    a_comma_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_COMMA) |=> (r_state == ST_DIGIT))
        else $error("comma not followed by digit");

    // The sign is emitted only for negative numbers
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_SIGN) |-> i_status.neg)
        else $error("sign emitted for non-negative number");
`endif

endmodule

`default_nettype wire

[rtl/core/decimal_text_with_thousands_groups.sv]
// Sequence: a load step, the bit-serial binary-to-BCD conversion, a skip
// of up to 19 leading zeros and a sign check, then one character per cycle
// while the output is not stalled. A new number is taken only in idle,
// once the last character of the previous one has been issued.
// Reset: synchronous active low; returns to idle and drops output valid.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_with_thousands_groups (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_number_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_text_char,
    output logic             o_final_char
);
    import dtg_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    // Controller
    dtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_op       (op)
    );

    // Datapath and output register
    dtg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_number_in  (i_number_in),
        .i_op         (op),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_text_char  (o_text_char),
        .o_final_char (o_final_char)
    );

endmodule

`default_nettype wire

[test/decimal_text_with_thousands_groups_tb.sv]
// Testbench for decimal_text_with_thousands_groups: drives signed 64-bit numbers and checks
// the grouped decimal text, character by character, against a built-in formatter.
// Depends on dtg_pkg and the block's RTL only.
`timescale 1ns / 1ps

module decimal_text_with_thousands_groups_tb;
    import dtg_pkg::*;

    localparam int GROUP_LEN     = 3;
    localparam int MAX_CHARS     = 26;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AT_ITEM  = 30;
    localparam int RANDOM_ITEMS  = 247;

    // one character of formatted text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_glyph;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] number_drv = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_text_char;
    logic        o_final_char;

    logic [63:0] number_requests [$];
    t_glyph      expected_text [$];
    int          total_requests = 0;
    int          requests_taken = 0;
    int          errors = 0;
    int          cycles = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;
    logic        hold_off;

    decimal_text_with_thousands_groups u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_number_in  (number_drv),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_text_char  (o_text_char),
        .o_final_char (o_final_char)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
    endtask

    // Format one number as grouped decimal text and queue its characters
    function automatic void predict_text(input logic [63:0] number);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [3:0]  digits [0:MAX_DIGITS-1];
        t_glyph      text [0:MAX_CHARS-1];
        int          ndig;
        int          n;
        bit          negative;
        mask     = {64{1'b1}} >> (64 - NUMBER_WIDTH);
        raw      = number & mask;
        negative = raw[NUMBER_WIDTH-1];
        mag      = negative ? ((~raw + 64'd1) & mask) : raw;
        if (negative && mag == 64'd0) begin
            mag = 64'd1 << (NUMBER_WIDTH - 1);
        end
        // least significant digit first
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            ndig++;
        end while (mag != 64'd0 && ndig < MAX_DIGITS);
        n = 0;
        if (negative) begin
            text[n] = '{ch: CHAR_MINUS, last: 1'b0};
            n++;
        end
        // separators only between digits, groups counted from the right
        for (int i = 0; i < ndig; i++) begin
            if (i > 0 && (ndig - i) % GROUP_LEN == 0) begin
                text[n] = '{ch: CHAR_COMMA, last: 1'b0};
                n++;
            end
            text[n] = '{ch: CHAR_ZERO + 8'(digits[ndig - 1 - i]), last: 1'b0};
            n++;
        end
        for (int k = 0; k < n; k++) begin
            expected_text.push_back('{ch: text[k].ch, last: (k == n - 1)});
        end
    endfunction

    // Random number: full-width, bounded digit count, near a power of ten, or short
    function automatic logic [63:0] random_number();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        p = 64'd1;
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: begin
                k = $urandom_range(1, 19);
                for (int i = 0; i < k; i++) p = p * 64'd10;
                v = {$urandom, $urandom} % p;
            end
            2: begin
                k = $urandom_range(0, 18);
                for (int i = 0; i < k; i++) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: v = 64'($urandom_range(0, 999999));
        endcase
        return ($urandom_range(1) != 0) ? -v : v;
    endfunction

    // Idle percentages per phase: sender light / receiver heavy, then swapped, then none
    function automatic int send_idle_pct(input int taken);
        if (taken < 100) return 9;
        if (taken < 200) return 73;
        return 0;
    endfunction

    function automatic int recv_stall_pct(input int taken);
        if (taken < 100) return 73;
        if (taken < 200) return 9;
        return 0;
    endfunction

    // Driver: offers queued requests, holds payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_text(number_drv);
                requests_taken <= requests_taken + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (number_requests.size() > 0 &&
                    (hold_off || $urandom_range(99) >= send_idle_pct(requests_taken))) begin
                    in_valid   <= 1'b1;
                    number_drv <= number_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off once HOLD_AT_ITEM requests are taken, so the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && requests_taken >= HOLD_AT_ITEM) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    assign hold_off = (hold_cnt != 0);

    // Receiver stall
    always @(posedge i_clk) begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct(requests_taken));
    end

    // Monitor: compare each accepted character with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_glyph want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h", o_text_char));
            end else begin
                want = expected_text.pop_front();
                if (o_text_char !== want.ch) begin
                    report_mismatch($sformatf("text_char 0x%02h, want 0x%02h",
                                              o_text_char, want.ch));
                end
                if (o_final_char !== want.last) begin
                    report_mismatch($sformatf("final_char %0b, want %0b (char 0x%02h)",
                                              o_final_char, want.last, want.ch));
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("decimal_text_with_thousands_groups_tb failed");
            $finish;
        end
    end

    initial begin
        // directed: zero, sign, digit-count boundaries, sign before a full group, extremes
        number_requests.push_back(64'd0);
        number_requests.push_back(64'd1);
        number_requests.push_back(-64'sd1);
        number_requests.push_back(64'd9);
        number_requests.push_back(64'd10);
        number_requests.push_back(64'd99);
        number_requests.push_back(64'd100);
        number_requests.push_back(-64'sd100);
        number_requests.push_back(64'd999);
        number_requests.push_back(-64'sd999);
        number_requests.push_back(64'd1000);
        number_requests.push_back(-64'sd1000);
        number_requests.push_back(64'd123456);
        number_requests.push_back(-64'sd999999);
        number_requests.push_back(64'd1000000);
        number_requests.push_back(-64'sd123456789);
        number_requests.push_back(64'd999999999999999999);
        number_requests.push_back(64'd1000000000000000000);
        number_requests.push_back(-64'sd1000000000000000000);
        number_requests.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        number_requests.push_back(64'h8000_0000_0000_0000);
        number_requests.push_back(64'h8000_0000_0000_0001);
        number_requests.push_back(64'hFFFF_FFFF_FFFF_FC18);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            number_requests.push_back(random_number());
        end
        total_requests = number_requests.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < total_requests || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", expected_text.size()));
        end
        if (errors == 0) begin
            $display("decimal_text_with_thousands_groups_tb passed");
        end else begin
            $display("decimal_text_with_thousands_groups_tb failed");
        end
        $finish;
    end

endmodule
